// ===== hw/rtl/gcap_pkg.sv =====
// ----------------------------------------------------------------------------
// gcap_pkg
// Shared types, constants and the class/id decoder for the acknowledge parser.
// ----------------------------------------------------------------------------
package gcap_pkg;

    localparam int unsigned POS_W = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] ACK_ID      = 8'h01;
    localparam logic [7:0] CFG_CLASS   = 8'h06;

    localparam logic [7:0] ID_MSG  = 8'h01;
    localparam logic [7:0] ID_GNSS = 8'h3E;
    localparam logic [7:0] ID_SBAS = 8'h17;
    localparam logic [7:0] ID_RATE = 8'h08;
    localparam logic [7:0] ID_PORT = 8'h00;

    localparam logic [POS_W-1:0] HEADER_LEN    = 4'd4;
    localparam logic [POS_W-1:0] ACK_FRAME_LEN = 4'd10;
    localparam logic [POS_W-1:0] BAD_FRAME_LEN = 4'd1;

    typedef enum logic [2:0] {
        ACK_NONE = 3'd0,
        ACK_MSG  = 3'd1,
        ACK_GNSS = 3'd2,
        ACK_SBAS = 3'd3,
        ACK_RATE = 3'd4,
        ACK_PORT = 3'd5
    } ack_kind_t;

    typedef struct packed {
        logic      frame_done;
        ack_kind_t ack_kind;
    } parse_result_t;

    function automatic ack_kind_t decode_kind(input logic [7:0] cls, input logic [7:0] id);
        ack_kind_t kind;
        kind = ACK_NONE;
        if (cls == CFG_CLASS) begin
            unique case (id)
                ID_MSG:  kind = ACK_MSG;
                ID_GNSS: kind = ACK_GNSS;
                ID_SBAS: kind = ACK_SBAS;
                ID_RATE: kind = ACK_RATE;
                ID_PORT: kind = ACK_PORT;
                default: kind = ACK_NONE;
            endcase
        end
        return kind;
    endfunction

endpackage

// ===== hw/rtl/gcap_parser.sv =====
// ----------------------------------------------------------------------------
// gcap_parser
// Frame buffer, position and length state, and the per-byte parse logic.
// ----------------------------------------------------------------------------
module gcap_parser
    import gcap_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic [7:0]    rx_byte,
    output parse_result_t result
);

    localparam int unsigned IDX_W = $clog2(BUFFER_BYTES);
    localparam logic [POS_W:0] DEPTH_W1 = (POS_W+1)'(BUFFER_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUFFER_BYTES - 1);

    logic [7:0]       buf_reg [BUFFER_BYTES];
    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [POS_W-1:0] frame_length_reg, frame_length_next;

    logic [POS_W-1:0] pos_sat;
    logic [POS_W:0]   pos_inc;
    logic [7:0]       b0, b1, b3, b6, b7;

    assign pos_sat = ({1'b0, byte_position_reg} >= DEPTH_W1) ? LAST_POS : byte_position_reg;
    assign pos_inc = {1'b0, pos_sat} + (POS_W+1)'(1);

    // Buffer view after this byte is stored: the incoming byte overrides its slot.
    assign b0 = (pos_sat == POS_W'(0)) ? rx_byte : buf_reg[0];
    assign b1 = (pos_sat == POS_W'(1)) ? rx_byte : buf_reg[1];
    assign b3 = (pos_sat == POS_W'(3)) ? rx_byte : buf_reg[3];
    assign b6 = (pos_sat == POS_W'(6)) ? rx_byte : buf_reg[6];
    assign b7 = (pos_sat == POS_W'(7)) ? rx_byte : buf_reg[7];

    always_comb begin
        byte_position_next = pos_inc[POS_W-1:0];
        frame_length_next  = frame_length_reg;
        result.frame_done  = 1'b0;
        result.ack_kind    = ACK_NONE;
        if (pos_inc <= {1'b0, HEADER_LEN}) begin
            if (b0 != SYNC_FIRST) begin
                byte_position_next = '0;
            end else if (pos_inc == {1'b0, HEADER_LEN}) begin
                if (b1 == SYNC_SECOND && b3 == ACK_ID) begin
                    frame_length_next = ACK_FRAME_LEN;
                end else begin
                    frame_length_next  = BAD_FRAME_LEN;
                    byte_position_next = '0;
                end
            end
        end else if (pos_inc >= {1'b0, frame_length_reg}) begin
            byte_position_next = '0;
            result.frame_done  = 1'b1;
            result.ack_kind    = decode_kind(b6, b7);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
            frame_length_reg  <= '0;
        end else if (step_en) begin
            byte_position_reg <= byte_position_next;
            frame_length_reg  <= frame_length_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            buf_reg[pos_sat[IDX_W-1:0]] <= rx_byte;
        end
    end

`ifndef SYNTH
    // A frame with a good header ends at ten bytes, others earlier, so the position never reaches ten.
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_position_reg < ACK_FRAME_LEN)
        else $error("byte position ran past the frame length");

    // The payload part of a frame is only entered after a good header.
    a_len_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_position_reg > HEADER_LEN |-> frame_length_reg == ACK_FRAME_LEN)
        else $error("payload position without a good header");

    a_done_resets_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.frame_done |=> byte_position_reg == '0)
        else $error("position not cleared after a completed frame");
`endif

endmodule

// ===== hw/rtl/gnss_config_ack_parser.sv =====
// A byte from s_* passes the input register, then the result register, to m_*;
// they decouple the two sides. One byte per cycle while m_tready is high.
// The parse state advances when a byte moves from the input to the result register.
// Reset (aresetn low, synchronous) clears both valid flags and the frame position;
// the frame buffer itself is not reset.
// ----------------------------------------------------------------------------
// gnss_config_ack_parser
// Byte-stream recognizer for configuration acknowledge frames.
// ----------------------------------------------------------------------------
module gnss_config_ack_parser
    import gcap_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 12
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] ack_kind, [7:3] zero
    output logic       m_tlast    // frame_done
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    parse_result_t out_result_reg;
    parse_result_t step_result;
    logic          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    gcap_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_result_reg.frame_done;
    assign m_tdata  = {5'b0, out_result_reg.ack_kind};

`ifndef SYNTH
    a_kind_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[2:0] == ACK_NONE)
        else $error("ack kind reported without a completed frame");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= ACK_PORT && m_tdata[7:3] == 5'b0)
        else $error("ack kind out of range");

    // A held input byte must never be dropped while the result side stalls.
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input byte lost");
`endif

endmodule
